// File: rtl/lpgc_pkg.sv
// lpgc_pkg: shared constants, result codes and the command/status structs
// of the linear-probing group counter. No dependencies.
`timescale 1ns / 1ps

package lpgc_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_WIDTH_DEF   = 32;

    localparam int KEY_IN_W   = 32;   // group_key field
    localparam int COUNT_W    = 32;   // group_count field
    localparam int SLOT_OUT_W = 10;   // slot_index field
    localparam int CFG_W      = 11;   // slots_in_use register
    localparam int M_TDATA_W  = 48;
    localparam int M_TUSER_W  = 3;

    localparam logic [CFG_W-1:0]   CFG_RESET = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // remainder bits resolved per cycle by the hash unit
    localparam int MOD_STEP   = 4;
    localparam int MOD_CYCLES = KEY_IN_W / MOD_STEP;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_KEY_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic clear;     // write one zero word of the clearing sweep
        logic load;      // capture an accepted item
        logic mod_step;  // one step of the hash remainder
        logic check;     // evaluate the slot word just read
        logic out_load;  // move the result into the output register
    } lpgc_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic key_in_zero;
        logic mod_last;
        logic found;       // slot holds the key or is empty
        logic probe_last;  // every active slot has been probed
        logic out_free;
    } lpgc_sts_t;

endpackage

// File: rtl/lpgc_ctrl.sv
// lpgc_ctrl: sequencer for clearing, hashing, probing and result hand-off.
// Depends on lpgc_pkg; drives lpgc_datapath through lpgc_cmd_t.
`timescale 1ns / 1ps

module lpgc_ctrl
    import lpgc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  lpgc_sts_t sts,
    output lpgc_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_MOD    = 6'b000100,
        S_READ   = 6'b001000,
        S_CHECK  = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    state_next = sts.key_in_zero ? S_RESULT : S_MOD;
                end
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = (sts.found || sts.probe_last) ? S_RESULT : S_READ;
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    a_nonzero_hashes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !sts.key_in_zero) |=> (state_reg == S_MOD))
        else $error("nonzero key did not start the hash");

    a_read_then_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |=> (state_reg == S_CHECK))
        else $error("slot read not followed by check");

    a_result_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && sts.out_free) |=> (state_reg == S_IDLE))
        else $error("result not handed off when output free");

endmodule

// File: rtl/lpgc_datapath.sv
// lpgc_datapath: config register, key modulo unit, slot/probe counters,
// key+count table memory and output register. Depends on lpgc_pkg.
`timescale 1ns / 1ps

module lpgc_datapath
    import lpgc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lpgc_cmd_t            cmd,
    output lpgc_sts_t            sts,
    input  logic                 cfg_valid,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [KEY_IN_W-1:0]  s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W = KEY_WIDTH + COUNT_W;
    localparam int MCNT_W = $clog2(MOD_CYCLES);
    localparam int PAD_W  = M_TDATA_W - COUNT_W - SLOT_OUT_W;
    localparam logic [KEY_IN_W-1:0] KEY_MASK = (KEY_WIDTH >= KEY_IN_W) ?
        {KEY_IN_W{1'b1}} : KEY_IN_W'((64'd1 << KEY_WIDTH) - 64'd1);

    // configuration and active slot count
    logic [CFG_W-1:0] slots_reg;
    logic [31:0]      cfg_wide;
    logic [CNT_W-1:0] n_act;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            slots_reg <= cfg_data;
        end
    end

    assign cfg_wide = 32'(slots_reg);
    always_comb begin
        if (cfg_wide == 32'd0) begin
            n_act = CNT_W'(1);
        end else if (cfg_wide > 32'(TABLE_DEPTH)) begin
            n_act = CNT_W'(TABLE_DEPTH);
        end else begin
            n_act = CNT_W'(cfg_wide);
        end
    end

    // item capture
    logic [KEY_IN_W-1:0]  key_masked;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_IN_W-1:0]  key_sh_reg, key_sh_next;
    logic                 last_reg;

    assign key_masked      = s_tdata & KEY_MASK;
    assign sts.key_in_zero = (key_masked == '0);

    // key modulo n, MOD_STEP bits per cycle
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [MCNT_W-1:0] mod_cnt_reg;

    always_comb begin
        logic [CNT_W:0]   t;
        logic [CNT_W-1:0] r;
        logic [KEY_IN_W-1:0] sh;
        r  = rem_reg;
        sh = key_sh_reg;
        t  = '0;
        for (int i = 0; i < MOD_STEP; i++) begin
            t  = {r, sh[KEY_IN_W-1]};
            sh = sh << 1;
            if (t >= {1'b0, n_act}) begin
                t = t - {1'b0, n_act};
            end
            r = t[CNT_W-1:0];
        end
        rem_next    = r;
        key_sh_next = sh;
    end

    assign sts.mod_last = (mod_cnt_reg == MCNT_W'(MOD_CYCLES - 1));

    // probe position
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  probe_reg;
    logic [CNT_W-1:0]  slot_inc;
    logic [31:0]       slot_wide;

    assign slot_inc       = CNT_W'(slot_reg) + CNT_W'(1);
    assign sts.probe_last = ((probe_reg + CNT_W'(1)) == n_act);
    assign slot_wide      = 32'(slot_reg);

    // table memory: key in the upper bits, count in the lower
    logic [WORD_W-1:0]    mem [TABLE_DEPTH];
    logic [WORD_W-1:0]    rd_q;
    logic [SLOT_W-1:0]    clr_cnt_reg;
    logic                 we;
    logic [SLOT_W-1:0]    wa;
    logic [WORD_W-1:0]    wd;
    logic [KEY_WIDTH-1:0] held_key;
    logic [COUNT_W-1:0]   held_cnt, cnt_inc;
    logic                 hit, empty;

    assign held_key  = rd_q[WORD_W-1:COUNT_W];
    assign held_cnt  = rd_q[COUNT_W-1:0];
    assign hit       = (held_key == key_reg);
    assign empty     = (held_key == '0);
    assign sts.found = hit || empty;
    assign cnt_inc   = (held_cnt == COUNT_MAX) ? held_cnt : held_cnt + COUNT_W'(1);

    assign sts.clr_last = (clr_cnt_reg == SLOT_W'(TABLE_DEPTH - 1));

    always_comb begin
        we = 1'b0;
        wa = slot_reg;
        wd = {key_reg, cnt_inc};
        if (cmd.clear) begin
            we = 1'b1;
            wa = clr_cnt_reg;
            wd = '0;
        end else if (cmd.check && sts.found) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_q <= mem[slot_reg];
    end

    // pending result and output register
    logic [SLOT_OUT_W-1:0] res_slot_reg;
    logic [COUNT_W-1:0]    res_cnt_reg;
    logic                  res_new_reg;
    status_t               res_status_reg;
    logic                  res_last_unused;
    logic                  m_valid_reg;
    logic [SLOT_OUT_W-1:0] m_slot_reg;
    logic [COUNT_W-1:0]    m_cnt_reg;
    logic                  m_new_reg;
    status_t               m_status_reg;
    logic                  m_last_reg;

    assign res_last_unused = 1'b0;
    assign sts.out_free    = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            mod_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            end
            if (cmd.load) begin
                mod_cnt_reg <= '0;
            end else if (cmd.mod_step) begin
                mod_cnt_reg <= mod_cnt_reg + MCNT_W'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg        <= KEY_WIDTH'(key_masked);
            key_sh_reg     <= key_masked;
            rem_reg        <= '0;
            last_reg       <= s_tlast;
            res_slot_reg   <= '0;
            res_cnt_reg    <= '0;
            res_new_reg    <= 1'b0;
            res_status_reg <= (key_masked == '0) ? ST_KEY_ZERO : ST_OK;
        end
        if (cmd.mod_step) begin
            rem_reg    <= rem_next;
            key_sh_reg <= key_sh_next;
            if (sts.mod_last) begin
                slot_reg  <= rem_next[SLOT_W-1:0];
                probe_reg <= '0;
            end
        end
        if (cmd.check) begin
            if (sts.found) begin
                res_slot_reg   <= slot_wide[SLOT_OUT_W-1:0];
                res_cnt_reg    <= cnt_inc;
                res_new_reg    <= !hit;
                res_status_reg <= ST_OK;
            end else if (sts.probe_last) begin
                res_status_reg <= ST_FULL;
            end else begin
                // wrap from the last active slot back to zero
                slot_reg  <= (slot_inc >= n_act) ? '0 : slot_inc[SLOT_W-1:0];
                probe_reg <= probe_reg + CNT_W'(1);
            end
        end
        if (cmd.out_load) begin
            m_slot_reg   <= res_slot_reg;
            m_cnt_reg    <= res_cnt_reg;
            m_new_reg    <= res_new_reg;
            m_status_reg <= res_status_reg;
            m_last_reg   <= last_reg | res_last_unused;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_cnt_reg, m_slot_reg};
    assign m_tuser  = {m_status_reg, m_new_reg};
    assign m_tlast  = m_last_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten while held");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.check && sts.found) |=> (res_cnt_reg != '0))
        else $error("found or inserted key has zero count");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.check && !sts.found && sts.probe_last) |=> (res_status_reg == ST_FULL))
        else $error("exhausted probe not flagged as full");

endmodule

// File: rtl/linear_probing_group_count_core.sv
// linear_probing_group_count_core: top level of the hash-table group counter.
// Each item is accepted, then the key is reduced modulo the slot count (4 bits a
// cycle), then each probe does a registered memory read followed by a
// compare/update, and the result is moved into the output register. A new item
// is taken only once the previous result has entered the output register. After
// reset a clearing sweep writes zero to all TABLE_DEPTH slots; no item is taken
// meanwhile, config writes are.
// Uses lpgc_pkg, lpgc_ctrl and lpgc_datapath.
`timescale 1ns / 1ps

module linear_probing_group_count_core
    import lpgc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration: slots_in_use
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [KEY_IN_W-1:0]  s_tdata,   // [31:0] group_key
    input  logic                 s_tlast,   // batch_end
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [9:0] slot_index, [41:10] group_count, zero pad
    output logic [M_TUSER_W-1:0] m_tuser,   // [0] new_group, [2:1] status_code
    output logic                 m_tlast    // batch_done
);

    lpgc_cmd_t cmd;
    lpgc_sts_t sts;

    assign cfg_ready = 1'b1;

    lpgc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpgc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: tb/tb_linear_probing_group_count_core.sv
// tb_linear_probing_group_count_core: self-checking bench for the linear-probing
// group counter; predicts slot, count, new-group flag, status and batch_done per key.
// Depends on lpgc_pkg and linear_probing_group_count_core.
`timescale 1ns / 1ps

module tb_linear_probing_group_count_core;
    import lpgc_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_LEN    = 3000;
    localparam int TAIL_CYCLES = 64;

    typedef struct packed {
        logic [KEY_IN_W-1:0] key;
        logic                last;
    } key_item_t;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic [COUNT_W-1:0]    count;
        logic                  new_group;
        status_t               status;
        logic                  done;
    } group_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [KEY_IN_W-1:0]  s_tdata   = '0;   // [31:0] group_key
    logic                 s_tlast   = 1'b0; // batch_end
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [9:0] slot_index, [41:10] group_count, zero pad
    logic [M_TUSER_W-1:0] m_tuser;          // [0] new_group, [2:1] status_code
    logic                 m_tlast;          // batch_done

    // predictor state
    logic [KEY_IN_W-1:0] key_tbl [DEPTH];
    logic [COUNT_W-1:0]  cnt_tbl [DEPTH];
    logic [CFG_W-1:0]    slots_reg = CFG_RESET;

    key_item_t     key_fifo [$];
    group_result_t result_q [$];
    logic [31:0]   key_pool [$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          fail_cnt       = 0;
    int unsigned cycle_cnt      = 0;
    logic        hold_req       = 1'b0;
    logic        hold_seen      = 1'b0;
    int          hold_left      = 0;

    linear_probing_group_count_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic group_result_t count_group(logic [KEY_IN_W-1:0] key, logic last);
        group_result_t r;
        int unsigned   n;
        int unsigned   slot;
        int unsigned   p;
        r        = '0;
        r.status = ST_OK;
        r.done   = last;
        if (key == '0) begin
            r.status = ST_KEY_ZERO;
            return r;
        end
        n = slots_reg;
        if (n == 0) n = 1;
        if (n > DEPTH) n = DEPTH;
        slot = key % n;
        for (p = 0; p < n; p++) begin
            if (key_tbl[slot] == key || key_tbl[slot] == '0) begin
                r.new_group = (key_tbl[slot] == '0);
                key_tbl[slot] = key;
                if (cnt_tbl[slot] != COUNT_MAX) cnt_tbl[slot] = cnt_tbl[slot] + 1;
                r.slot  = slot[SLOT_OUT_W-1:0];
                r.count = cnt_tbl[slot];
                return r;
            end
            slot++;
            if (slot >= n) slot = 0;
        end
        // every active slot taken by other keys
        r.status = ST_FULL;
        return r;
    endfunction

    // driver: keeps an item on the bus until it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                result_q.push_back(count_group(s_tdata, s_tlast));
            end
            if (!s_tvalid || s_tready) begin
                if (key_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= key_fifo[0].key;
                    s_tlast  <= key_fifo[0].last;
                    void'(key_fifo.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started once on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_req && !hold_seen) begin
            hold_left <= HOLD_LEN;
            hold_seen <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // monitor: compares each taken result with the oldest prediction
    always @(posedge aclk) begin
        group_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual tdata %h tuser %h tlast %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    fail_cnt++;
                end else begin
                    want = result_q.pop_front();
                    check_field("slot_index", 32'(want.slot), 32'(m_tdata[9:0]));
                    check_field("group_count", want.count, m_tdata[41:10]);
                    check_field("new_group", 32'(want.new_group), 32'(m_tuser[0]));
                    check_field("status_code", 32'(want.status), 32'(m_tuser[2:1]));
                    check_field("batch_done", 32'(want.done), 32'(m_tlast));
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_slots(input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        slots_reg = value;
    endtask

    task automatic push_key(input logic [31:0] key, input logic last);
        key_item_t it;
        it.key  = key;
        it.last = last;
        key_fifo.push_back(it);
    endtask

    // sampled at the falling edge so the driver's updates have settled
    task automatic wait_idle();
        while (key_fifo.size() != 0 || s_tvalid || result_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge aclk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic fill_pool(input int n);
        key_pool.delete();
        repeat (n) key_pool.push_back($urandom() | 32'd1);
    endtask

    // mix of repeated pool keys, keys sharing low bits, random keys and zero
    task automatic queue_keys(input int n);
        int unsigned roll;
        logic [31:0] key;
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < 5) key = '0;
            else if (roll < 15) key = ($urandom() << 10) | $urandom_range(7);
            else if (roll < 40) key = $urandom();
            else key = key_pool[$urandom_range(key_pool.size() - 1)];
            push_key(key, $urandom_range(7) == 0);
        end
    endtask

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            key_tbl[i] = '0;
            cnt_tbl[i] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reserved key, largest key, home-slot collision, wrap to slot 0
        @(negedge aclk);
        push_key(32'h0000_0000, 1'b1);
        push_key(32'hFFFF_FFFF, 1'b0);
        push_key(32'hFFFF_FFFF, 1'b1);
        push_key(32'd1, 1'b0);
        push_key(32'd1025, 1'b0);
        push_key(32'd1, 1'b1);
        push_key(32'd1023, 1'b0);
        wait_idle();

        // zero slot count behaves as one slot: full table and a hit
        write_slots('0);
        @(negedge aclk);
        push_key(32'd5, 1'b0);
        push_key(32'd1023, 1'b1);
        wait_idle();

        // above the table depth acts as the full depth
        write_slots('1);
        @(negedge aclk);
        push_key(32'h8000_0000, 1'b1);
        wait_idle();

        // shrunk table: entries beyond the active count are not probed
        write_slots(11'd3);
        @(negedge aclk);
        push_key(32'd7, 1'b0);
        push_key(32'd1, 1'b0);
        push_key(32'd1025, 1'b0);
        push_key(32'h8000_0000, 1'b1);
        wait_idle();

        write_slots(11'd1024);
        set_idling(0, 0);
        fill_pool(64);
        queue_keys(200);
        wait_idle();

        write_slots(11'd16);
        set_idling(70, 0);
        fill_pool(24);
        queue_keys(150);
        wait_idle();

        write_slots(11'd1);
        set_idling(0, 70);
        fill_pool(4);
        queue_keys(60);
        wait_idle();

        write_slots(11'd1000);
        set_idling(23, 23);
        fill_pool(48);
        queue_keys(200);
        wait_idle();

        // receiver holds off while the sender keeps offering
        write_slots(11'd1024);
        set_idling(0, 0);
        fill_pool(32);
        hold_req = 1'b1;
        queue_keys(150);
        wait_idle();

        write_slots(11'd2047);
        set_idling(0, 70);
        fill_pool(40);
        queue_keys(150);
        wait_idle();

        write_slots(11'd600);
        set_idling(23, 23);
        fill_pool(40);
        queue_keys(140);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_cnt == 0 && result_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
